@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/mmm_pkg.sv @@
// ----------------------------------------------------------------------------
// mmm_pkg
// shared types and constants of the matrix multiply unit
// ----------------------------------------------------------------------------
package mmm_pkg;

  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int REQ_W     = 2;
  localparam int CFG_W     = 2;
  localparam int FRAC_BITS = 16;

  localparam logic [REQ_W-1:0] REQ_WR_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;

  localparam logic [CFG_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_W-1:0] CFG_B_COLS = 2'd3;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd;
    logic             rd_first;
    logic             rd_last;
    logic             echo;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             elem_last;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic out_taken;
  } status_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] x,
                                              input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    r = x;
    if (x == '0) begin
      r = DIM_W'(1);
    end else if (x > max_dim) begin
      r = max_dim;
    end
    return r;
  endfunction

endpackage

@@ sv/matrix_matrix_multiply_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_matrix_multiply_unit
// element loads are accepted while idle; a start emits rows x cols results
// each result is computed over K inner steps, K = a_cols (1 on echo), with
// one store read per inner step through the single multiply-accumulate
// the next result is issued once the previous one is taken
// synchronous reset: dimensions return to 8, stores keep contents (undefined)
// ----------------------------------------------------------------------------
module matrix_matrix_multiply_unit #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mmm_pkg::REQ_W-1:0]    req_type,
  input  logic [mmm_pkg::IDX_W-1:0]    row_index,
  input  logic [mmm_pkg::IDX_W-1:0]    col_index,
  input  logic signed [31:0]           elem_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mmm_pkg::IDX_W-1:0]    out_row,
  output logic [mmm_pkg::IDX_W-1:0]    out_col,
  output logic signed [31:0]           out_value,
  output logic                         dim_error,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mmm_pkg::CFG_W-1:0]    cfg_index,
  input  logic [mmm_pkg::DIM_W-1:0]    cfg_data
);

  mmm_pkg::cmd_t    cmd;
  mmm_pkg::status_t status;

  mmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  mmm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .row_index  (row_index),
    .col_index  (col_index),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .dim_error  (dim_error),
    .last       (last)
  );

endmodule

@@ sv/mmm_ram.sv @@
// ----------------------------------------------------------------------------
// mmm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmm_ctrl
// sequencer: configuration registers, request decode and element loops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mmm_pkg::REQ_W-1:0]    req_type,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mmm_pkg::CFG_W-1:0]    cfg_index,
  input  logic [mmm_pkg::DIM_W-1:0]    cfg_data,
  input  mmm_pkg::status_t             status,
  output mmm_pkg::cmd_t                cmd
);

  localparam int DW = mmm_pkg::DIM_W;
  localparam int IW = mmm_pkg::IDX_W;
  localparam logic [DW-1:0] MAX_D = DW'(MAX_DIM);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  state_t        state;
  logic [DW-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [IW-1:0] i_cnt, j_cnt, k_cnt;
  logic          err_mode;

  logic [DW-1:0] ar, ac, br, bc, col_lim, k_lim;
  logic          accept, i_last, j_last, k_last, elem_last;

  assign ar = mmm_pkg::dim_of(a_rows, MAX_D);
  assign ac = mmm_pkg::dim_of(a_cols, MAX_D);
  assign br = mmm_pkg::dim_of(b_rows, MAX_D);
  assign bc = mmm_pkg::dim_of(b_cols, MAX_D);

  assign col_lim = err_mode ? ac : bc;
  assign k_lim   = err_mode ? DW'(1) : ac;

  assign i_last    = DW'(i_cnt) == ar - DW'(1);
  assign j_last    = DW'(j_cnt) == col_lim - DW'(1);
  assign k_last    = DW'(k_cnt) == k_lim - DW'(1);
  assign elem_last = i_last && j_last;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.rd        = (state == S_ISSUE);
    cmd.rd_first  = (k_cnt == '0);
    cmd.rd_last   = k_last;
    cmd.echo      = err_mode;
    cmd.i         = i_cnt;
    cmd.j         = j_cnt;
    cmd.k         = k_cnt;
    cmd.elem_last = elem_last;
    if (accept) begin
      case (req_type)
        mmm_pkg::REQ_WR_A: cmd.wr_a = 1'b1;
        mmm_pkg::REQ_WR_B: cmd.wr_b = 1'b1;
        default:           cmd.wr_a = 1'b0;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DW'(8);
      a_cols <= DW'(8);
      b_rows <= DW'(8);
      b_cols <= DW'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mmm_pkg::CFG_A_ROWS: a_rows <= cfg_data;
        mmm_pkg::CFG_A_COLS: a_cols <= cfg_data;
        mmm_pkg::CFG_B_ROWS: b_rows <= cfg_data;
        mmm_pkg::CFG_B_COLS: b_cols <= cfg_data;
        default:             a_rows <= a_rows;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      i_cnt    <= '0;
      j_cnt    <= '0;
      k_cnt    <= '0;
      err_mode <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && req_type == mmm_pkg::REQ_START) begin
            state    <= S_ISSUE;
            i_cnt    <= '0;
            j_cnt    <= '0;
            k_cnt    <= '0;
            err_mode <= (ac != br);
          end
        end
        S_ISSUE: begin
          if (k_last) begin
            k_cnt <= '0;
            state <= S_WAIT;
          end else begin
            k_cnt <= k_cnt + IW'(1);
          end
        end
        S_WAIT: begin
          if (status.out_taken) begin
            if (elem_last) begin
              state <= S_IDLE;
            end else begin
              state <= S_ISSUE;
              if (j_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + IW'(1);
              end else begin
                j_cnt <= j_cnt + IW'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_k_in_range, clk, rst, state == S_ISSUE, DW'(k_cnt) < k_lim)
  `ASSERT_NEXT(a_idle_after_final, clk, rst, status.out_taken && elem_last, state == S_IDLE)
  `ASSERT_IMPL(a_idle_out_empty, clk, rst, state == S_IDLE, !status.out_busy)

endmodule

@@ sv/mmm_datapath.sv @@
// ----------------------------------------------------------------------------
// mmm_datapath
// element stores, multiply-accumulate pipeline, rounding and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmm_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mmm_pkg::cmd_t             cmd,
  output mmm_pkg::status_t          status,
  input  logic [mmm_pkg::IDX_W-1:0] row_index,
  input  logic [mmm_pkg::IDX_W-1:0] col_index,
  input  logic signed [31:0]        elem_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mmm_pkg::IDX_W-1:0] out_row,
  output logic [mmm_pkg::IDX_W-1:0] out_col,
  output logic signed [31:0]        out_value,
  output logic                      dim_error,
  output logic                      last
);

  localparam int EW    = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
  localparam int PW    = 2 * EW;
  localparam int ACC_W = PW + 3;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int FB    = mmm_pkg::FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FB - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-EW+1){1'b1}}, {(EW-1){1'b0}}};

  logic          in_range;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] rdata_a, rdata_b;

  logic                    v1, first1, last1, echo1;
  logic                    v2, first2, last2;
  logic                    v3;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [EW-1:0]    a_s, b_s;
  logic signed [PW-1:0]    a_ext, prod_next;
  logic signed [ACC_W-1:0] rnd, scaled;
  logic signed [EW-1:0]    sat;

  assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign waddr    = AW'(32'(row_index) * MAX_DIM + 32'(col_index));
  assign raddr_a  = AW'(32'(cmd.i) * MAX_DIM + 32'(cmd.echo ? cmd.j : cmd.k));
  assign raddr_b  = AW'(32'(cmd.k) * MAX_DIM + 32'(cmd.j));

  mmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (waddr),
    .wdata (elem_value[EW-1:0]),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (waddr),
    .wdata (elem_value[EW-1:0]),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // echo passes a through as a times one
  assign a_s       = rdata_a;
  assign b_s       = rdata_b;
  assign a_ext     = PW'(a_s);
  assign prod_next = echo1 ? (a_ext <<< FB) : (a_s * b_s);

  // round half up, then saturate
  assign rnd    = acc + HALF;
  assign scaled = rnd >>> FB;
  always_comb begin
    if (scaled > SAT_MAX) begin
      sat = SAT_MAX[EW-1:0];
    end else if (scaled < SAT_MIN) begin
      sat = SAT_MIN[EW-1:0];
    end else begin
      sat = scaled[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1;
      v3 <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= cmd.rd_first;
    last1  <= cmd.rd_last;
    echo1  <= cmd.echo;
    first2 <= first1;
    last2  <= last1;
    if (v1) begin
      prod <= prod_next;
    end
    if (v2) begin
      acc <= first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v3) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      out_row   <= cmd.i;
      out_col   <= cmd.j;
      out_value <= 32'(sat);
      dim_error <= cmd.echo;
      last      <= cmd.elem_last;
    end
  end

  assign status.out_busy  = out_valid;
  assign status.out_taken = out_valid && !out_stall;

  `ASSERT_IMPL(a_no_overwrite, clk, rst, v3, !out_valid)
  `ASSERT_IMPL(a_wr_pipe_quiet, clk, rst, cmd.wr_a || cmd.wr_b, !v1 && !v2 && !v3)
  `ASSERT_IMPL(a_out_from_pipe, clk, rst, $rose(out_valid), $past(v3))

endmodule

@@ verif/matrix_matrix_multiply_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_matrix_multiply_unit_test
// Loads matrices A and B element by element, requests products under many
// dimension settings (mismatched and aliased ones too) and checks every
// emitted result word against a fixed-point predictor kept in the bench.
// The sender works in bursts and gaps, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module matrix_matrix_multiply_unit_test;

  localparam int RW = mmm_pkg::REQ_W;
  localparam int IW = mmm_pkg::IDX_W;
  localparam int CW = mmm_pkg::CFG_W;
  localparam int DW = mmm_pkg::DIM_W;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 250;
  localparam int DIM_MAX       = 8;
  localparam logic [RW-1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [IW-1:0]      row;
    logic [IW-1:0]      col;
    logic signed [31:0] value;
    logic               err;
    logic               last;
  } elem_word_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [RW-1:0]      req_type;
  logic [IW-1:0]      row_index;
  logic [IW-1:0]      col_index;
  logic signed [31:0] elem_value;
  logic               out_valid;
  logic               out_stall;
  logic [IW-1:0]      out_row;
  logic [IW-1:0]      out_col;
  logic signed [31:0] out_value;
  logic               dim_error;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CW-1:0]      cfg_index;
  logic [DW-1:0]      cfg_data;

  // bench copy of the stores and dimension registers
  logic signed [31:0] mat_a [64];
  logic signed [31:0] mat_b [64];
  bit                 a_written [64];
  bit                 b_written [64];
  logic [DW-1:0]      dim_ar, dim_ac, dim_br, dim_bc;

  elem_word_t pending_elems [$];
  elem_word_t want;

  int cycle_count   = 0;
  int errors        = 0;
  int items_sent    = 0;
  int starts_sent   = 0;
  int words_checked = 0;
  int burst_left    = 0;
  int hold_count    = 0;
  int rx_mode       = 0;
  int rx_mode_left  = 0;

  matrix_matrix_multiply_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .row_index  (row_index),
    .col_index  (col_index),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .dim_error  (dim_error),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int eff_dim(input logic [DW-1:0] r);
    if (r == '0) return 1;
    if (r > DIM_MAX) return DIM_MAX;
    return int'(r);
  endfunction

  // exact dot product, rounded once to 16 fraction bits, then saturated
  function automatic logic signed [31:0] round_dot(input int i, input int j, input int n);
    longint prod, hi_sum, lo_sum, acc;
    hi_sum = 0;
    lo_sum = 0;
    for (int k = 0; k < n; k++) begin
      prod = longint'(mat_a[i*DIM_MAX+k]) * longint'(mat_b[k*DIM_MAX+j]);
      hi_sum += prod >>> 16;
      lo_sum += prod & 64'hFFFF;
    end
    acc = hi_sum + (lo_sum + 32768) / 65536;
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic void apply_request(input logic [RW-1:0] req,
                                        input logic [IW-1:0] row,
                                        input logic [IW-1:0] col,
                                        input logic signed [31:0] val);
    int ar, ac, br, bc;
    elem_word_t w;
    ar = eff_dim(dim_ar);
    ac = eff_dim(dim_ac);
    br = eff_dim(dim_br);
    bc = eff_dim(dim_bc);
    case (req)
      mmm_pkg::REQ_WR_A: begin
        mat_a[{row, col}] = val;
        a_written[{row, col}] = 1'b1;
      end
      mmm_pkg::REQ_WR_B: begin
        mat_b[{row, col}] = val;
        b_written[{row, col}] = 1'b1;
      end
      mmm_pkg::REQ_START: begin
        if (ac != br) begin
          // inner dimensions differ: A comes back unchanged
          for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < ac; j++) begin
              w.row   = IW'(i);
              w.col   = IW'(j);
              w.value = mat_a[i*DIM_MAX+j];
              w.err   = 1'b1;
              w.last  = (i == ar - 1) && (j == ac - 1);
              pending_elems.push_back(w);
            end
          end
        end else begin
          for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < bc; j++) begin
              w.row   = IW'(i);
              w.col   = IW'(j);
              w.value = round_dot(i, j, ac);
              w.err   = 1'b0;
              w.last  = (i == ar - 1) && (j == bc - 1);
              pending_elems.push_back(w);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      4, 5: return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
      default: return 32'($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_dim();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return DW'($urandom_range(9, 15));
      2: return DW'(8);
      default: return DW'($urandom_range(1, 4));
    endcase
  endfunction

  // one input word, with burst and gap pacing on the sender side
  task automatic send_request(input logic [RW-1:0] req,
                              input logic [IW-1:0] row,
                              input logic [IW-1:0] col,
                              input logic signed [31:0] val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= req;
    row_index  <= row;
    col_index  <= col;
    elem_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(req, row, col, val);
    if (req != REQ_NONE) items_sent++;
    if (req == mmm_pkg::REQ_START) starts_sent++;
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CW-1:0] idx, input logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mmm_pkg::CFG_A_ROWS: dim_ar = val;
      mmm_pkg::CFG_A_COLS: dim_ac = val;
      mmm_pkg::CFG_B_ROWS: dim_br = val;
      default:             dim_bc = val;
    endcase
  endtask

  task automatic set_dims(input logic [DW-1:0] ar, input logic [DW-1:0] ac,
                          input logic [DW-1:0] br, input logic [DW-1:0] bc);
    drain();
    write_reg(mmm_pkg::CFG_A_ROWS, ar);
    write_reg(mmm_pkg::CFG_A_COLS, ac);
    write_reg(mmm_pkg::CFG_B_ROWS, br);
    write_reg(mmm_pkg::CFG_B_COLS, bc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // load any operand entry the next start reads that was never written
  task automatic fill_operands();
    int ar, ac, br, bc;
    ar = eff_dim(dim_ar);
    ac = eff_dim(dim_ac);
    br = eff_dim(dim_br);
    bc = eff_dim(dim_bc);
    for (int i = 0; i < ar; i++) begin
      for (int j = 0; j < ac; j++) begin
        if (!a_written[i*DIM_MAX+j]) begin
          send_request(mmm_pkg::REQ_WR_A, IW'(i), IW'(j), rand_elem());
        end
      end
    end
    if (ac == br) begin
      for (int i = 0; i < br; i++) begin
        for (int j = 0; j < bc; j++) begin
          if (!b_written[i*DIM_MAX+j]) begin
            send_request(mmm_pkg::REQ_WR_B, IW'(i), IW'(j), rand_elem());
          end
        end
      end
    end
  endtask

  task automatic test_full_size();
    // reset dimensions are 8 x 8 by 8 x 8
    fill_operands();
    send_request(mmm_pkg::REQ_START, '0, '0, '0);
    drain();
  endtask

  task automatic test_saturation_rounding();
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_request(mmm_pkg::REQ_WR_A, 3'd0, 3'd0, 32'sh7FFF_FFFF);
    send_request(mmm_pkg::REQ_WR_B, 3'd0, 3'd0, 32'sh7FFF_FFFF);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    send_request(mmm_pkg::REQ_WR_B, 3'd0, 3'd0, 32'sh8000_0000);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    send_request(mmm_pkg::REQ_WR_A, 3'd0, 3'd0, 32'sh8000_0000);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    // half an lsb either side of zero, ties go up
    send_request(mmm_pkg::REQ_WR_A, 3'd0, 3'd0, 32'sh0000_0001);
    send_request(mmm_pkg::REQ_WR_B, 3'd0, 3'd0, 32'sh0000_8000);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    send_request(mmm_pkg::REQ_WR_A, 3'd0, 3'd0, 32'shFFFF_FFFF);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    send_request(mmm_pkg::REQ_WR_A, 3'd0, 3'd0, 32'sh0001_0000);
    send_request(mmm_pkg::REQ_WR_B, 3'd0, 3'd0, 32'shFFFF_0000);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
  endtask

  task automatic test_dim_aliases();
    // zero acts as one, above eight acts as eight
    set_dims(4'd3, 4'd0, 4'd2, 4'd5);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    set_dims(4'd2, 4'd9, 4'd8, 4'd0);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    set_dims(4'd0, 4'd7, 4'd13, 4'd1);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    set_dims(4'd15, 4'd8, 4'd8, 4'd12);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
  endtask

  task automatic test_unknown_request();
    set_dims(4'd2, 4'd3, 4'd3, 4'd2);
    send_request(REQ_NONE, 3'd7, 3'd0, $urandom);
    send_request(REQ_NONE, 3'd0, 3'd7, $urandom);
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    drain();
  endtask

  task automatic test_receiver_hold();
    set_dims(4'd3, 4'd3, 4'd3, 4'd3);
    hold_count = 400;
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    repeat (10) begin
      send_request(mmm_pkg::REQ_WR_B, 3'($urandom), 3'($urandom), rand_elem());
    end
    send_request(mmm_pkg::REQ_START, 3'd0, 3'd0, 32'sd0);
    drain();
  endtask

  task automatic test_random_phases();
    int goal;
    logic [DW-1:0] ar, ac, br, bc;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      ar = rand_dim();
      ac = rand_dim();
      bc = rand_dim();
      if ($urandom_range(0, 3) == 0) br = DW'(eff_dim(ac) % DIM_MAX + 1);
      else br = ac;
      set_dims(ar, ac, br, bc);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 6)) begin
          send_request($urandom_range(0, 1) ? mmm_pkg::REQ_WR_B : mmm_pkg::REQ_WR_A,
                       3'($urandom), 3'($urandom), rand_elem());
        end
        if ($urandom_range(0, 4) == 0) begin
          send_request(REQ_NONE, 3'($urandom), 3'($urandom), $urandom);
        end
        fill_operands();
        send_request(mmm_pkg::REQ_START, 3'($urandom), 3'($urandom), $urandom);
      end
    end
    drain();
  endtask

  // receiver: long hold when asked, otherwise stall modes of random length
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_count > 0) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count - 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(5, 60);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none, actual row %0d col %0d value %h",
                 $time, out_row, out_col, out_value);
      end else begin
        want = pending_elems.pop_front();
        check_field("out_row", 32'(want.row), 32'(out_row));
        check_field("out_col", 32'(want.col), 32'(out_col));
        check_field("out_value", want.value, out_value);
        check_field("dim_error", 32'(want.err), 32'(dim_error));
        check_field("last", 32'(want.last), 32'(last));
        words_checked++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t timeout with %0d result words outstanding", $time, pending_elems.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= '0;
    row_index  <= '0;
    col_index  <= '0;
    elem_value <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    dim_ar = DW'(8);
    dim_ac = DW'(8);
    dim_br = DW'(8);
    dim_bc = DW'(8);
    for (int n = 0; n < 64; n++) begin
      a_written[n] = 1'b0;
      b_written[n] = 1'b0;
      mat_a[n] = '0;
      mat_b[n] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_size();
    test_saturation_rounding();
    test_dim_aliases();
    test_unknown_request();
    test_receiver_hold();
    test_random_phases();
    drain();

    $display("run covered %0d loads and starts (%0d starts), %0d result words checked",
             items_sent, starts_sent, words_checked);
    $display("including saturation, rounding ties, dimension aliases and mismatch echo");
    if (errors == 0 && pending_elems.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ matrix_matrix_multiply_unit.f @@
+incdir+sv
sv/mmm_pkg.sv
sv/mmm_ram.sv
sv/mmm_ctrl.sv
sv/mmm_datapath.sv
sv/matrix_matrix_multiply_unit.sv
verif/matrix_matrix_multiply_unit_test.sv
